// ----- sv/bsm_pkg.sv -----
// ---------------------------------------------------------------------------
// bsm_pkg: shared types and constants
// Word formats, widths and the controller/datapath interface of the
// bounding-sphere merge block.
// ---------------------------------------------------------------------------
`default_nettype none

package bsm_pkg;

    localparam int COORD_BITS = 32;
    localparam int RAD_BITS   = COORD_BITS - 1;
    localparam int DIFF_BITS  = COORD_BITS + 1;        // center difference
    localparam int PROD_BITS  = 2 * DIFF_BITS;         // product of two magnitudes
    localparam int ROOT_BITS  = COORD_BITS + 2;        // distance, quotient
    localparam int RADC_BITS  = 2 * ROOT_BITS;         // padded radicand
    localparam int SREM_BITS  = COORD_BITS + 3;        // sqrt partial remainder
    localparam int NUM_BITS   = PROD_BITS + 1;         // dividend of axis shift
    localparam int SUM3_BITS  = ROOT_BITS + 2;
    localparam int ROOT_STEPS = ROOT_BITS;
    localparam int DIV_STEPS  = ROOT_BITS;
    localparam int AXES       = 3;
    localparam int CNT_BITS   = 6;

    localparam logic [RAD_BITS-1:0] RAD_MAX = '1;

    typedef enum logic [1:0] {
        ACT_SEED    = 2'd0,
        ACT_KEEP    = 2'd1,
        ACT_REPLACE = 2'd2,
        ACT_MERGE   = 2'd3
    } action_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] center_x;
        logic signed [COORD_BITS-1:0] center_y;
        logic signed [COORD_BITS-1:0] center_z;
        logic [RAD_BITS-1:0]          radius;
        logic                         first_group;
    } in_word_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] out_center_x;
        logic signed [COORD_BITS-1:0] out_center_y;
        logic signed [COORD_BITS-1:0] out_center_z;
        logic [RAD_BITS-1:0]          out_radius;
        action_t                      action;
    } out_word_t;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_axis;
        logic       acc_en;
        logic [1:0] acc_axis;
        logic       prod_phase;   // 0: squares of differences, 1: shift numerators
        logic       root_step;
        logic       decide;
        logic       div_step;
        logic       commit;
        action_t    action;
    } cmd_t;

    typedef struct packed {
        logic contained;
        logic encloses;
    } stat_t;

endpackage

`default_nettype wire

// ----- sv/bounding_sphere_merge_core.sv -----
// ---------------------------------------------------------------------------
// bounding_sphere_merge_core: running enclosing sphere
// Merges each incoming sphere into a running bounding sphere and returns
// the updated sphere with the action taken.
// ---------------------------------------------------------------------------
// One word at a time: the next word is taken only once the last has been
// committed; the 34-step square root and the 34-step shift division lanes
// set the rate. A finished word waits in the output register meanwhile.
// Reset clears the running sphere to center 0, radius 0.
`default_nettype none

module bounding_sphere_merge_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire bsm_pkg::in_word_t  item,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output bsm_pkg::out_word_t      result
);

    bsm_pkg::cmd_t  cmd;
    bsm_pkg::stat_t stat;

    bsm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .first_group  (item.first_group),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    bsm_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

endmodule

`default_nettype wire

// ----- sv/bsm_ctrl.sv -----
// ---------------------------------------------------------------------------
// bsm_ctrl: sequencer
// Unless the word is a seed, steps the datapath through squares, square root, decision
// and, for a merge, shift products and division, then commits the word to the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module bsm_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    input  wire logic          first_group,
    output logic               item_stall,
    output logic               result_valid,
    input  wire logic          result_stall,
    input  wire bsm_pkg::stat_t stat,
    output bsm_pkg::cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_ROOT,
        S_DECIDE,
        S_PROD,
        S_DIV,
        S_COMMIT
    } state_t;

    state_t                          state_reg, state_next;
    logic [bsm_pkg::CNT_BITS-1:0]    cnt_reg, cnt_next;
    bsm_pkg::action_t                action_reg, action_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            slot_free;

    assign slot_free    = !out_valid_reg || !result_stall;
    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.action     = action_reg;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        action_next    = action_reg;
        out_valid_next = out_valid_reg && result_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    if (first_group)
                    begin
                        action_next = bsm_pkg::ACT_SEED;
                        state_next  = S_COMMIT;
                    end
                    else
                    begin
                        state_next = S_SQ;
                    end
                end
            end
            S_SQ, S_PROD:
            begin
                cmd.prod_phase = (state_reg == S_PROD);
                cmd.mul_en     = (cnt_reg < bsm_pkg::CNT_BITS'(bsm_pkg::AXES));
                cmd.mul_axis   = cnt_reg[1:0];
                cmd.acc_en     = (cnt_reg != '0);
                cmd.acc_axis   = 2'(cnt_reg - 1'b1);
                if (cnt_reg == bsm_pkg::CNT_BITS'(bsm_pkg::AXES))
                begin
                    cnt_next   = '0;
                    state_next = (state_reg == S_SQ) ? S_ROOT : S_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (cnt_reg == bsm_pkg::CNT_BITS'(bsm_pkg::ROOT_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_DECIDE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                priority if (stat.contained)
                begin
                    action_next = bsm_pkg::ACT_KEEP;
                    state_next  = S_COMMIT;
                end
                else if (stat.encloses)
                begin
                    action_next = bsm_pkg::ACT_REPLACE;
                    state_next  = S_COMMIT;
                end
                else
                begin
                    action_next = bsm_pkg::ACT_MERGE;
                    state_next  = S_PROD;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == bsm_pkg::CNT_BITS'(bsm_pkg::DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_COMMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_COMMIT:
            begin
                if (slot_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            action_reg    <= bsm_pkg::ACT_SEED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            action_reg    <= action_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/bsm_datapath.sv -----
// ---------------------------------------------------------------------------
// bsm_datapath: arithmetic of the sphere merge
// Shared multiplier, bit-pair square root, three restoring division lanes,
// running sphere and output word register.
// ---------------------------------------------------------------------------
`default_nettype none

module bsm_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bsm_pkg::in_word_t item,
    input  wire bsm_pkg::cmd_t     cmd,
    output bsm_pkg::stat_t         stat,
    output bsm_pkg::out_word_t     result
);

    localparam int CB = bsm_pkg::COORD_BITS;
    localparam int RB = bsm_pkg::RAD_BITS;
    localparam int DB = bsm_pkg::DIFF_BITS;
    localparam int PB = bsm_pkg::PROD_BITS;
    localparam int TB = bsm_pkg::ROOT_BITS;
    localparam int AB = bsm_pkg::RADC_BITS;
    localparam int SB = bsm_pkg::SREM_BITS;
    localparam int NB = bsm_pkg::NUM_BITS;
    localparam int S3 = bsm_pkg::SUM3_BITS;

    bsm_pkg::in_word_t     in_reg;
    bsm_pkg::out_word_t    out_reg;
    logic signed [CB-1:0]  run_c_reg [bsm_pkg::AXES];
    logic signed [CB-1:0]  run_c_next [bsm_pkg::AXES];
    logic [RB-1:0]         run_r_reg, run_r_next;
    logic signed [DB-1:0]  diff_reg [bsm_pkg::AXES];
    logic [DB-1:0]         mag [bsm_pkg::AXES];
    logic signed [CB-1:0]  in_c [bsm_pkg::AXES];
    logic signed [CB-1:0]  new_c [bsm_pkg::AXES];
    logic [PB-1:0]         mul_reg;
    logic [AB-1:0]         sum_reg;
    logic [SB-1:0]         srem_reg;
    logic [TB-1:0]         root_reg;
    logic [TB:0]           nr_reg;
    logic [DB-1:0]         delta_reg;
    logic [TB-1:0]         lrem_reg [bsm_pkg::AXES];
    logic [TB-1:0]         lnq_reg [bsm_pkg::AXES];

    logic [DB-1:0]         mul_a, mul_b;
    logic [SB+1:0]         sq_t;
    logic [SB:0]           sq_trial;
    logic                  sq_ge;
    logic [NB-1:0]         num;
    logic [TB:0]           dist_r, dist_run;
    logic [S3-1:0]         sum3;
    logic [TB:0]           nr_calc;
    logic [TB:0]           delta_calc;

    assign in_c[0] = item.center_x;
    assign in_c[1] = item.center_y;
    assign in_c[2] = item.center_z;

    always_comb
    begin
        for (int k = 0; k < bsm_pkg::AXES; k++)
        begin
            mag[k] = diff_reg[k][DB-1] ? DB'(-diff_reg[k]) : DB'(diff_reg[k]);
        end
    end

    // shared multiplier operands
    assign mul_a = mag[cmd.mul_axis];
    assign mul_b = cmd.prod_phase ? delta_reg : mag[cmd.mul_axis];

    // square root: one result bit per step
    assign sq_t     = {srem_reg, sum_reg[AB-1:AB-2]};
    assign sq_trial = {root_reg, 2'b01};
    assign sq_ge    = (sq_t >= {1'b0, sq_trial});

    assign num = {1'b0, mul_reg} + NB'(root_reg >> 1);

    assign dist_r     = {1'b0, root_reg} + (TB+1)'(in_reg.radius);
    assign dist_run   = {1'b0, root_reg} + (TB+1)'(run_r_reg);
    assign stat.contained = (dist_r <= (TB+1)'(run_r_reg));
    assign stat.encloses  = (dist_run <= (TB+1)'(in_reg.radius));
    assign sum3       = S3'(root_reg) + S3'(run_r_reg) + S3'(in_reg.radius);
    assign nr_calc    = sum3[S3-1:1];
    assign delta_calc = nr_calc - (TB+1)'(run_r_reg);

    // commit values
    always_comb
    begin
        logic [TB+1:0] off;
        logic [TB+1:0] acc;
        for (int k = 0; k < bsm_pkg::AXES; k++)
        begin
            off = {2'b00, lnq_reg[k]};
            if (diff_reg[k][DB-1])
            begin
                off = -off;
            end
            acc      = (TB+2)'(run_c_reg[k]) + off;
            new_c[k] = acc[CB-1:0];
        end
    end

    always_comb
    begin
        unique case (cmd.action)
            bsm_pkg::ACT_SEED, bsm_pkg::ACT_REPLACE:
            begin
                run_c_next[0] = in_reg.center_x;
                run_c_next[1] = in_reg.center_y;
                run_c_next[2] = in_reg.center_z;
                run_r_next    = in_reg.radius;
            end
            bsm_pkg::ACT_MERGE:
            begin
                run_c_next = new_c;
                run_r_next = (nr_reg > (TB+1)'(bsm_pkg::RAD_MAX)) ?
                             bsm_pkg::RAD_MAX : nr_reg[RB-1:0];
            end
            default:
            begin
                run_c_next = run_c_reg;
                run_r_next = run_r_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < bsm_pkg::AXES; k++)
            begin
                run_c_reg[k] <= '0;
            end
            run_r_reg <= '0;
        end
        else if (cmd.commit)
        begin
            run_c_reg <= run_c_next;
            run_r_reg <= run_r_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg   <= item;
            sum_reg  <= '0;
            srem_reg <= '0;
            root_reg <= '0;
            for (int k = 0; k < bsm_pkg::AXES; k++)
            begin
                diff_reg[k] <= DB'(in_c[k]) - DB'(run_c_reg[k]);
            end
        end

        if (cmd.mul_en)
        begin
            mul_reg <= PB'(mul_a) * PB'(mul_b);
        end

        if (cmd.acc_en)
        begin
            if (cmd.prod_phase)
            begin
                lrem_reg[cmd.acc_axis] <= TB'(num[NB-1:TB]);
                lnq_reg[cmd.acc_axis]  <= num[TB-1:0];
            end
            else
            begin
                sum_reg <= sum_reg + AB'(mul_reg);
            end
        end

        if (cmd.root_step)
        begin
            sum_reg <= sum_reg << 2;
            if (sq_ge)
            begin
                srem_reg <= SB'(sq_t - (SB+2)'(sq_trial));
                root_reg <= {root_reg[TB-2:0], 1'b1};
            end
            else
            begin
                srem_reg <= sq_t[SB-1:0];
                root_reg <= {root_reg[TB-2:0], 1'b0};
            end
        end

        if (cmd.decide)
        begin
            nr_reg    <= nr_calc;
            delta_reg <= delta_calc[DB-1:0];
        end

        if (cmd.div_step)
        begin
            for (int k = 0; k < bsm_pkg::AXES; k++)
            begin
                if ({lrem_reg[k], lnq_reg[k][TB-1]} >= {1'b0, root_reg})
                begin
                    lrem_reg[k] <= TB'({lrem_reg[k], lnq_reg[k][TB-1]} - {1'b0, root_reg});
                    lnq_reg[k]  <= {lnq_reg[k][TB-2:0], 1'b1};
                end
                else
                begin
                    lrem_reg[k] <= {lrem_reg[k][TB-2:0], lnq_reg[k][TB-1]};
                    lnq_reg[k]  <= {lnq_reg[k][TB-2:0], 1'b0};
                end
            end
        end

        if (cmd.commit)
        begin
            out_reg.out_center_x <= run_c_next[0];
            out_reg.out_center_y <= run_c_next[1];
            out_reg.out_center_z <= run_c_next[2];
            out_reg.out_radius   <= run_r_next;
            out_reg.action       <= cmd.action;
        end
    end

    assign result = out_reg;

endmodule

`default_nettype wire
